// File: rtl/ile_pkg.sv
// Shared constants, codes and types for the indexed list engine.
package ile_pkg;

   localparam int CAPACITY    = 64;
   localparam int VALUE_W     = 32;
   localparam int KIND_W      = 3;
   localparam int POS_W       = 7;
   localparam int STATUS_W    = 2;
   localparam int LEN_W       = 7;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int GROUP_SIZE  = 8;
   localparam int NUM_GROUPS  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   localparam logic [KIND_W-1:0] KIND_READ   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_HEAD   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TAIL   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_AT     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DELETE = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic               ins;
      logic               del;
      logic [CMP_W-1:0]   target;
      logic [CMP_W-1:0]   rd_pos;
      logic [VALUE_W-1:0] value;
   } ile_cell_ctrl_type;

endpackage

// File: rtl/ile_channels.sv
// Request and response channel interfaces with valid/ready handshake.
interface ile_req_if import ile_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic        [KIND_W-1:0]  kind;
   logic        [POS_W-1:0]   position;
   logic signed [VALUE_W-1:0] item_value;

   modport source (output valid, kind, position, item_value, input ready);
   modport sink   (input valid, kind, position, item_value, output ready);
endinterface

interface ile_rsp_if import ile_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  read_value;
   logic        [STATUS_W-1:0] status;
   logic        [LEN_W-1:0]    list_length;

   modport source (output valid, read_value, status, list_length, input ready);
   modport sink   (input valid, read_value, status, list_length, output ready);
endinterface

// File: rtl/ile_cell.sv
// One list entry: holds, shifts toward the tail on insert, toward the head on delete.
module ile_cell import ile_pkg::*; (
   input  logic                clock,
   input  logic [IDX_W-1:0]    cell_index,
   input  ile_cell_ctrl_type   ctrl,
   input  logic [VALUE_W-1:0]  left_value,
   input  logic [VALUE_W-1:0]  right_value,
   output logic [VALUE_W-1:0]  value_out,
   output logic [VALUE_W-1:0]  read_out
);

   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;
   logic [CMP_W-1:0]   my_index;

   assign my_index = CMP_W'(cell_index);

   always_comb begin
      value_in = value_ff;
      if (ctrl.ins) begin
         if (my_index > ctrl.target) begin
            value_in = left_value;
         end else if (my_index == ctrl.target) begin
            value_in = ctrl.value;
         end
      end else if (ctrl.del) begin
         if (my_index >= ctrl.target) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;
   assign read_out  = (my_index == ctrl.rd_pos) ? value_ff : '0;

endmodule

// File: rtl/ile_read_tree.sv
// Registered OR tree that gathers the one selected entry from the cell row.
module ile_read_tree import ile_pkg::*; (
   input  logic                clock,
   input  logic                capture,
   input  logic [VALUE_W-1:0]  cell_read [CAPACITY],
   output logic [VALUE_W-1:0]  read_data
);

   logic [VALUE_W-1:0] group_ff [NUM_GROUPS];
   logic [VALUE_W-1:0] group_in [NUM_GROUPS];

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g * GROUP_SIZE + k < CAPACITY) begin
               group_in[g] = group_in[g] | cell_read[g * GROUP_SIZE + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         group_ff <= group_in;
      end
   end

   always_comb begin
      read_data = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         read_data = read_data | group_ff[g];
      end
   end

endmodule

// File: rtl/indexed_list_engine.sv
// Indexed list engine: a row of shifting entry cells with a gathered read path.
// The response passes the stage-1 register, then the response register, and transfers
// when the response side is ready. Throughput: one operation per cycle unless the
// response side stalls; the cell row shifts in the transfer cycle
// and the read result passes one registered OR stage before the response register.
// Reset (synchronous, active high) empties the list and clears the pipeline;
// entry contents are not cleared and are only read below the current length.
module indexed_list_engine import ile_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ile_req_if.sink     req_ch,
   ile_rsp_if.source   rsp_ch
);

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic                s1_good_read_ff;
   logic [STATUS_W-1:0] s1_status_ff;
   logic [CNT_W-1:0]    s1_len_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [LEN_W-1:0]    rsp_len_ff;

   logic                advance;
   logic                accept;
   logic [CMP_W-1:0]    pos_ext;
   logic [CMP_W-1:0]    count_ext;
   logic                full;
   logic                good_read;
   logic [STATUS_W-1:0] status_next;
   ile_cell_ctrl_type   ctrl;
   logic [VALUE_W-1:0]  tree_data;

   logic [VALUE_W-1:0]  cell_value [CAPACITY];
   logic [VALUE_W-1:0]  cell_read  [CAPACITY];

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;

   assign pos_ext   = CMP_W'(req_ch.position);
   assign count_ext = CMP_W'(count_ff);
   assign full      = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      ctrl        = '0;
      ctrl.value  = req_ch.item_value;
      ctrl.rd_pos = pos_ext;
      good_read   = 1'b0;
      status_next = STATUS_DONE;
      count_in    = count_ff;
      case (req_ch.kind)
         KIND_READ: begin
            if (pos_ext < count_ext) begin
               good_read = 1'b1;
            end else begin
               status_next = STATUS_RANGE;
            end
         end
         KIND_HEAD: begin
            if (full) begin
               status_next = STATUS_FULL;
            end else begin
               ctrl.ins    = 1'b1;
               ctrl.target = '0;
               count_in    = count_ff + 1'b1;
            end
         end
         KIND_TAIL: begin
            if (full) begin
               status_next = STATUS_FULL;
            end else begin
               ctrl.ins    = 1'b1;
               ctrl.target = count_ext;
               count_in    = count_ff + 1'b1;
            end
         end
         KIND_AT: begin
            if (pos_ext > count_ext) begin
               status_next = STATUS_RANGE;
            end else if (full) begin
               status_next = STATUS_FULL;
            end else begin
               ctrl.ins    = 1'b1;
               ctrl.target = pos_ext;
               count_in    = count_ff + 1'b1;
            end
         end
         KIND_DELETE: begin
            if (pos_ext < count_ext) begin
               ctrl.del    = 1'b1;
               ctrl.target = pos_ext;
               count_in    = count_ff - 1'b1;
            end else begin
               status_next = STATUS_RANGE;
            end
         end
         default: begin
         end
      endcase
      if (!accept) begin
         ctrl.ins = 1'b0;
         ctrl.del = 1'b0;
         count_in = count_ff;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_W-1:0] left_value;
      logic [VALUE_W-1:0] right_value;
      if (i == 0) begin : g_head
         assign left_value = cell_value[i];
      end else begin : g_mid
         assign left_value = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_value = cell_value[i];
      end else begin : g_body
         assign right_value = cell_value[i+1];
      end
      ile_cell u_cell (
         .clock       (clock),
         .cell_index  (IDX_W'(i)),
         .ctrl        (ctrl),
         .left_value  (left_value),
         .right_value (right_value),
         .value_out   (cell_value[i]),
         .read_out    (cell_read[i])
      );
   end

   ile_read_tree u_read_tree (
      .clock     (clock),
      .capture   (accept),
      .cell_read (cell_read),
      .read_data (tree_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_good_read_ff <= good_read;
         s1_status_ff    <= status_next;
         s1_len_ff       <= count_in;
      end
      if (advance && s1_valid_ff) begin
         rsp_value_ff  <= s1_good_read_ff ? tree_data : '1;
         rsp_status_ff <= s1_status_ff;
         rsp_len_ff    <= LEN_W'(s1_len_ff);
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.read_value  = rsp_value_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.list_length = rsp_len_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("list length above capacity");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_FULL |-> rsp_len_ff == LEN_W'(CAPACITY))
      else $error("full status with list not at capacity");

   a_error_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == STATUS_RANGE || rsp_status_ff == STATUS_FULL)
      |-> rsp_value_ff == '1)
      else $error("error response without all-ones read value");

   a_delete_shrinks: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.kind == KIND_DELETE && pos_ext < count_ext
      |=> count_ff == $past(count_ff) - 1'b1)
      else $error("delete did not shrink the list");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff)
      else $error("pending operation lost under backpressure");

endmodule
